### rtl/core/frld_pkg.sv
// shared types and constants for the frame rms level decimator
package frld_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W = 7;
	localparam int MODE_W = 2;
	localparam int DIV_W = 13;
	localparam int CFG_W = 13;
	localparam int SUMSQ_W = 43;
	localparam int PHASE_W = 12;
	localparam int TOTAL_W = 19;
	localparam int DEF_MAX_FRAME_SAMPLES = 4096;
	localparam int DEF_MAX_GROUP_LEVELS = 4096;
	localparam int CNT_W = $clog2(DEF_MAX_FRAME_SAMPLES + 1);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
	localparam logic [15:0] FULL_SCALE = 16'd32767;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE  = 2'd0,
		MODE_FIRST = 2'd1,
		MODE_PEAK  = 2'd2,
		MODE_AVG   = 2'd3
	} mode_t;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_DIV  = 1'b1;

	// one queued frame-end or emitting packet-end job
	typedef struct packed {
		logic                   do_frame;
		logic [SUMSQ_W-1:0]     sumsq;
		logic [CNT_W-1:0]       count;
		logic                   do_emit;
		mode_t                  mode;
	} job_t;

endpackage

### rtl/core/frame_rms_level_decimator.sv
// top level: config registers, front end, job queue and back end
// channel  dir  fields (low bit first)
// s_axis   in   tdata: sample[15:0]; tuser: has_sample; tlast: frame_end, packet_end
// m_axis   out  tdata: level[6:0], pad
// cfg      in   index 0 reduce_mode, index 1 group_divider
// plain samples need no back-end job; a frame end queues one, which the back end runs as accept,
// setup and a downward level search from 100 to 0; grouping adds the output state
// and an average emission a 7-bit restoring divide in the back end
// the back end takes no new job while a level waits on m_axis
// a two-entry job queue lets the front keep taking samples meanwhile
// reset clears accumulators, group state and registers to their defaults
module frame_rms_level_decimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample
	input  logic        s_axis_tuser,   // has_sample
	input  logic [1:0]  s_axis_tlast,   // frame_end, packet_end
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [7:0]  m_axis_tdata,   // level
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [frld_pkg::CFG_W-1:0] cfg_wdata
);
	import frld_pkg::*;

	mode_t mode_q;
	logic [DIV_W-1:0] div_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	job_t fj, bj;
	job_t q_mem [2];
	logic [1:0] q_cnt_q;
	logic q_wp_q, q_rp_q;
	logic [LEVEL_W-1:0] lvl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			div_q <= 13'd2;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE)
				mode_q <= mode_t'(cfg_wdata[MODE_W-1:0]);
			else
				div_q <= cfg_wdata;
		end
	end

	frld_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sample(s_axis_tdata), .has_sample(s_axis_tuser),
		.frame_end(s_axis_tlast[0]), .packet_end(s_axis_tlast[1]),
		.mode(mode_q), .divider(div_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	// job queue between front and back
	assign fj_ready = (q_cnt_q != 2'd2);
	assign bj_valid = (q_cnt_q != 2'd0);
	assign bj = q_mem[q_rp_q];
	always_ff @(posedge clk) begin
		if (fj_valid && fj_ready)
			q_mem[q_wp_q] <= fj;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			q_wp_q <= 1'b0;
			q_rp_q <= 1'b0;
		end else begin
			if (fj_valid && fj_ready)
				q_wp_q <= !q_wp_q;
			if (bj_valid && bj_ready)
				q_rp_q <= !q_rp_q;
			q_cnt_q <= q_cnt_q + 2'(fj_valid && fj_ready) - 2'(bj_valid && bj_ready);
		end
	end

	frld_back u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .level(lvl)
	);

	assign m_axis_tdata = {1'b0, lvl};
endmodule

### rtl/core/frld_front.sv
// front end: accumulates squares per frame and tracks packet phase
module frld_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [frld_pkg::SAMPLE_W-1:0] sample,
	input  logic                            has_sample,
	input  logic                            frame_end,
	input  logic                            packet_end,
	input  frld_pkg::mode_t                 mode,
	input  logic [frld_pkg::DIV_W-1:0]      divider,
	output logic                            job_valid,
	input  logic                            job_ready,
	output frld_pkg::job_t                  job
);
	import frld_pkg::*;

	logic [SUMSQ_W-1:0] sumsq_q;
	logic [CNT_W-1:0] count_q;
	logic [PHASE_W-1:0] phase_q;
	logic [15:0] mag;
	logic [31:0] sq;
	logic take;
	logic add;
	logic [SUMSQ_W-1:0] sum_n;
	logic [CNT_W-1:0] cnt_n;
	logic [DIV_W-1:0] div_c;
	logic [DIV_W-1:0] ph_inc;
	logic need_job;

	// magnitude and square of the sample, next accumulator values, clamped divider and the job
	always_comb begin
		mag = sample[15] ? 16'(-sample) : 16'(sample);
		sq = 32'(mag) * 32'(mag);
		add = has_sample && (32'(count_q) < 32'(DEF_MAX_FRAME_SAMPLES));
		sum_n = add ? sumsq_q + SUMSQ_W'(sq) : sumsq_q;
		cnt_n = add ? count_q + 1'b1 : count_q;
		div_c = (divider < 13'd2) ? 13'd2 : ((divider > 13'd4096) ? 13'd4096 : divider);
		ph_inc = DIV_W'(phase_q) + 1'b1;
		need_job = frame_end || (packet_end && mode != MODE_NONE && phase_q == '0);
		in_ready = !need_job || job_ready;
		take = in_valid && in_ready;
		job_valid = in_valid && need_job;
		job.do_frame = frame_end && (cnt_n != '0);
		job.sumsq = sum_n;
		job.count = cnt_n;
		job.do_emit = packet_end && mode != MODE_NONE && phase_q == '0;
		job.mode = mode;
	end

	// frame accumulator and packet phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sumsq_q <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else if (take) begin
			sumsq_q <= frame_end ? '0 : sum_n;
			count_q <= frame_end ? '0 : cnt_n;
			if (packet_end)
				phase_q <= (ph_inc >= div_c) ? '0 : PHASE_W'(ph_inc);
		end
	end
endmodule

### rtl/core/frld_back.sv
// back end: level search, grouping, reduction and output register
module frld_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  frld_pkg::job_t                job,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [frld_pkg::LEVEL_W-1:0]  level
);
	import frld_pkg::*;

	localparam int CMP_W = 57;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_SEARCH, ST_DIV, ST_OUT} state_t;

	state_t state_q;
	job_t job_q;
	logic [CMP_W-1:0] rhs_q;
	logic [CMP_W-1:0] kn_q;
	logic [CMP_W-1:0] lhs_q;
	logic [CMP_W-1:0] step_q;
	logic [CMP_W-1:0] kn2_q;
	logic [LEVEL_W-1:0] r_q;
	logic [LEVEL_W-1:0] first_q, peak_q;
	logic [TOTAL_W-1:0] total_q;
	logic [16:0] size_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [4:0] bit_q;
	logic [LEVEL_W-1:0] level_q;
	logic valid_q;
	logic [CMP_W-1:0] ss_x;
	logic [CMP_W-1:0] n_x;
	logic [CMP_W-1:0] rhs_n;
	logic [CMP_W-1:0] kn_n;
	logic [CMP_W-1:0] kn_x10000;
	logic [CMP_W-1:0] kn_x199;
	logic [TOTAL_W+16:0] trial;

	// constant multiplies as shift and add: 10000 = 2^13+2^10+2^9+2^8+2^4,
	// 32767^2 = 2^30-2^16+1, 199 = 2^7+2^6+2^2+2^1+1
	always_comb begin
		ss_x = CMP_W'(job.sumsq);
		n_x = CMP_W'(job.count);
		rhs_n = (ss_x << 13) + (ss_x << 10) + (ss_x << 9) + (ss_x << 8) + (ss_x << 4);
		kn_n = (n_x << 30) - (n_x << 16) + n_x;
		kn_x10000 = (kn_q << 13) + (kn_q << 10) + (kn_q << 9) + (kn_q << 8) + (kn_q << 4);
		kn_x199 = (kn_q << 7) + (kn_q << 6) + (kn_q << 2) + (kn_q << 1) + kn_q;
		trial = 36'(size_q) << bit_q;
		job_ready = (state_q == ST_IDLE) && !valid_q;
		out_valid = valid_q;
		level = level_q;
	end

	// sequencer: r search downward one step a cycle, then a restoring divide for an average emission
	// lhs tracks r^2*32767^2*n, lowered by (2r-1)*32767^2*n per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			job_q <= '0;
			rhs_q <= '0;
			kn_q <= '0;
			lhs_q <= '0;
			step_q <= '0;
			kn2_q <= '0;
			r_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			level_q <= '0;
			first_q <= '0;
			peak_q <= '0;
			total_q <= '0;
			size_q <= '0;
		end else begin
			if (valid_q && out_ready)
				valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						job_q <= job;
						rhs_q <= rhs_n;
						kn_q <= kn_n;
						r_q <= LEVEL_MAX;
						state_q <= job.do_frame ? ST_PREP : ST_OUT;
					end
				end
				ST_PREP: begin
					lhs_q <= kn_x10000;
					step_q <= kn_x199;
					kn2_q <= kn_q << 1;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (r_q == '0 || lhs_q <= rhs_q) begin
						if (job_q.mode == MODE_NONE) begin
							level_q <= r_q;
							valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							if (32'(size_q) < 32'(DEF_MAX_GROUP_LEVELS)) begin
								if (size_q == '0) begin
									first_q <= r_q;
									peak_q <= r_q;
								end else if (r_q > peak_q)
									peak_q <= r_q;
								total_q <= total_q + TOTAL_W'(r_q);
								size_q <= size_q + 1'b1;
							end
							state_q <= ST_OUT;
						end
					end else begin
						r_q <= r_q - 1'b1;
						lhs_q <= lhs_q - step_q;
						step_q <= step_q - kn2_q;
					end
				end
				ST_OUT: begin
					if (!job_q.do_emit)
						state_q <= ST_IDLE;
					else if (size_q == '0)
						state_q <= ST_IDLE;
					else if (job_q.mode == MODE_AVG) begin
						rem_q <= total_q;
						quo_q <= '0;
						bit_q <= 5'd6;
						state_q <= ST_DIV;
					end else begin
						level_q <= (job_q.mode == MODE_FIRST) ? first_q : peak_q;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
					if (job_q.do_emit && !(size_q != '0 && job_q.mode == MODE_AVG)) begin
						first_q <= '0;
						peak_q <= '0;
						total_q <= '0;
						size_q <= '0;
					end
				end
				ST_DIV: begin
					if (36'(rem_q) >= trial) begin
						rem_q <= rem_q - TOTAL_W'(trial);
						quo_q[bit_q[2:0]] <= 1'b1;
					end
					if (bit_q == '0) begin
						level_q <= (36'(rem_q) >= trial) ? (quo_q | LEVEL_W'(1)) : quo_q;
						valid_q <= 1'b1;
						first_q <= '0;
						peak_q <= '0;
						total_q <= '0;
						size_q <= '0;
						state_q <= ST_IDLE;
					end else
						bit_q <= bit_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sim/tb_frame_rms_level_decimator.sv
// testbench for the frame rms level decimator: directed and random beats against a predictor
`timescale 1ns / 1ps

module tb_frame_rms_level_decimator;
	import frld_pkg::*;

	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_LEVELS = 4096;
	localparam int TAIL_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // sample
	logic        s_axis_tuser;   // has_sample
	logic [1:0]  s_axis_tlast;   // frame_end, packet_end
	logic        m_axis_tready;
	logic        m_axis_tvalid;
	logic [7:0]  m_axis_tdata;   // level[6:0], pad
	logic        cfg_we;
	logic        cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	frame_rms_level_decimator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	mode_t           cur_mode;
	logic [DIV_W-1:0] cur_div;
	logic [SUMSQ_W-1:0] acc_sumsq;
	int unsigned     acc_count;
	int unsigned     grp_first, grp_peak, grp_total, grp_size;
	int unsigned     phase;

	logic [LEVEL_W-1:0] level_q[$];
	int  err_count;
	int  hold_cycles;   // long receiver hold-off request
	bit  stall_en;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// largest r with (r*full)^2*n <= 10000*sumsq
	function automatic int unsigned frame_level(logic [SUMSQ_W-1:0] ss, int unsigned n);
		logic [63:0] rhs;
		logic [63:0] a;
		rhs = 64'(ss) * 64'd10000;
		for (int r = 100; r > 0; r--) begin
			a = 64'(r) * 64'd32767;
			if (a * a * 64'(n) <= rhs)
				return r;
		end
		return 0;
	endfunction

	function automatic void predict_beat(logic signed [15:0] smp, bit has, bit fend, bit pend);
		int unsigned lv, dv, mag, v;
		if (has && acc_count < MAX_SAMPLES) begin
			mag = (smp < 0) ? -int'(smp) : int'(smp);
			acc_sumsq += 43'(64'(mag) * 64'(mag));
			acc_count++;
		end
		if (fend) begin
			if (acc_count > 0) begin
				lv = frame_level(acc_sumsq, acc_count);
				if (cur_mode == MODE_NONE)
					level_q = {level_q, LEVEL_W'(lv)};
				else if (grp_size < MAX_LEVELS) begin
					if (grp_size == 0) begin
						grp_first = lv;
						grp_peak = lv;
					end else if (lv > grp_peak)
						grp_peak = lv;
					grp_total += lv;
					grp_size++;
				end
			end
			acc_sumsq = '0;
			acc_count = 0;
		end
		if (pend) begin
			dv = (cur_div < 2) ? 2 : (cur_div > 4096) ? 4096 : cur_div;
			if (cur_mode != MODE_NONE && phase == 0) begin
				if (grp_size > 0) begin
					case (cur_mode)
						MODE_FIRST: v = grp_first;
						MODE_PEAK: v = grp_peak;
						default: v = grp_total / grp_size;
					endcase
					level_q = {level_q, LEVEL_W'(v)};
				end
				grp_first = 0; grp_peak = 0; grp_total = 0; grp_size = 0;
			end
			phase = (phase + 1 >= dv) ? 0 : phase + 1;
		end
	endfunction

	// send one beat, with a random gap first when stalls are enabled
	task automatic send_beat(logic signed [15:0] smp, bit has, bit fend, bit pend);
		int gap;
		gap = stall_en ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= has;
		s_axis_tlast <= {pend, fend};
		do @(posedge clk); while (!s_axis_tready);
		predict_beat(smp, has, fend, pend);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (level_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_MODE)
			cur_mode = mode_t'(val[MODE_W-1:0]);
		else
			cur_div = val;
	endtask

	task automatic set_config(mode_t m, logic [CFG_W-1:0] d);
		wait_drain();
		write_reg(REG_MODE, CFG_W'(m));
		write_reg(REG_DIV, d);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stall per beat when stalls are enabled, and a long hold-off when asked
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = stall_en ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// level checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (level_q.size() == 0) begin
				$error("unexpected level beat %0d", m_axis_tdata[6:0]);
				err_count++;
			end else begin
				logic [LEVEL_W-1:0] exp_lv;
				exp_lv = level_q.pop_front();
				if (m_axis_tdata[6:0] !== exp_lv) begin
					$error("level: expected %0d actual %0d", exp_lv, m_axis_tdata[6:0]);
					err_count++;
				end
			end
		end
	end

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 64)) - 16'sd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// full scale, extremes, empty frame, bare packet ends
	task automatic test_directed();
		set_config(MODE_NONE, 13'd2);
		send_beat(16'sh7FFF, 1, 1, 0);
		send_beat(16'sh8000, 1, 1, 0);
		send_beat(16'sh0000, 1, 1, 0);
		send_beat(16'sh0000, 0, 1, 0);
		send_beat(16'sh1234, 1, 0, 0);
		send_beat(16'shEDCB, 1, 1, 1);
		send_beat(16'sh0000, 0, 0, 1);
		set_config(MODE_FIRST, 13'd2);
		send_beat(16'sh4000, 1, 1, 1);
		send_beat(16'sh7FFF, 1, 1, 1);
		send_beat(16'sh0000, 0, 0, 1);
		set_config(MODE_PEAK, 13'd3);
		send_beat(16'sh1000, 1, 1, 0);
		send_beat(16'sh7000, 1, 1, 0);
		send_beat(16'sh0000, 0, 0, 1);
		set_config(MODE_AVG, 13'd0);
		send_beat(16'sh2000, 1, 1, 0);
		send_beat(16'sh7FFF, 1, 1, 1);
		send_beat(16'sh0000, 0, 0, 1);
		send_beat(16'sh0000, 0, 0, 1);
		set_config(MODE_AVG, 13'h1FFF);
		send_beat(16'sh5555, 1, 1, 1);
	endtask

	// random frames and packets under one setting
	task automatic test_random(mode_t m, logic [CFG_W-1:0] d, int beats);
		set_config(m, d);
		for (int i = 0; i < beats; i++) begin
			bit fend, pend, has;
			has = ($urandom_range(0, 15) != 0);
			fend = ($urandom_range(0, 5) == 0);
			pend = fend ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 30) == 0);
			send_beat(rand_sample(), has, fend, pend);
		end
	endtask

	// receiver held off while frame ends keep coming
	task automatic test_backpressure();
		set_config(MODE_NONE, 13'd2);
		hold_cycles = 3000;
		for (int i = 0; i < 40; i++)
			send_beat(rand_sample(), 1, 1, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_wdata = '0;
		err_count = 0;
		hold_cycles = 0;
		stall_en = 1;
		cur_mode = MODE_NONE;
		cur_div = 13'd2;
		acc_sumsq = '0;
		acc_count = 0;
		grp_first = 0; grp_peak = 0; grp_total = 0; grp_size = 0;
		phase = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(MODE_NONE, 13'd2, 100);
		test_random(MODE_FIRST, 13'd2, 100);
		stall_en = 0;
		test_random(MODE_PEAK, 13'd3, 100);
		stall_en = 1;
		test_random(MODE_AVG, 13'd1, 100);
		test_random(MODE_PEAK, 13'd4096, 60);
		wait_drain();

		if (err_count == 0 && level_q.size() == 0)
			$display("** frame_rms_level_decimator: PASSED **");
		else
			$display("** frame_rms_level_decimator: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** frame_rms_level_decimator: FAILED **");
		$finish;
	end

endmodule

### sim.f
rtl/core/frld_pkg.sv
rtl/core/frld_front.sv
rtl/core/frld_back.sv
rtl/core/frame_rms_level_decimator.sv
sim/tb_frame_rms_level_decimator.sv
